@@ design/pva_pkg.sv @@
// Shared constants and arctangent table for the polar vector adder.
`timescale 1ns / 1ps
`default_nettype none
package pva_pkg;
    localparam int ATAN_ENTRIES = 24;
    localparam int FRAC_SHIFT   = 14;
    localparam int XY_W         = 34;   // rotation datapath width
    localparam int COMP_W       = 32;   // compensated component width
    localparam int VEC_W        = 36;   // vectoring datapath width

    localparam logic [30:0] GAIN_Q31    = 31'd1304065748;
    localparam logic [15:0] TURN_UNITS  = 16'd46080;
    localparam logic [15:0] RECIP45_Q21 = 16'd46604;      // ceil(2^21 / 45)
    localparam logic [28:0] RECIP45_Q34 = 29'd381774871;  // ceil(2^34 / 45)
    localparam logic [5:0]  DIV45       = 6'd45;
    localparam logic [31:0] HALF_TURN   = 32'h8000_0000;

    // atan(2^-i) as binary angle, 2^32 per turn
    function automatic logic [31:0] atan_val(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

@@ design/pva_in_if.sv @@
// Input channel: two polar vectors with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface pva_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] mag_a;
    logic [15:0] angle_a;
    logic [15:0] mag_b;
    logic [15:0] angle_b;
    modport source (output valid, mag_a, angle_a, mag_b, angle_b, input ready);
    modport sink   (input valid, mag_a, angle_a, mag_b, angle_b, output ready);
endinterface
`default_nettype wire

@@ design/pva_out_if.sv @@
// Output channel: resultant polar vector with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface pva_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] sum_magnitude;
    logic [15:0] sum_direction;
    modport source (output valid, sum_magnitude, sum_direction, input ready);
    modport sink   (input valid, sum_magnitude, sum_direction, output ready);
endinterface
`default_nettype wire

@@ design/pva_polar_to_xy.sv @@
// Pipelined polar to cartesian conversion: angle scaling, CORDIC rotation, gain.
`timescale 1ns / 1ps
`default_nettype none
module pva_polar_to_xy
    import pva_pkg::*;
#(
    parameter int STAGES = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic [15:0]              i_mag,
    input  wire logic [15:0]              i_angle,
    output logic                          o_valid,
    output logic signed [COMP_W-1:0]      o_x,
    output logic signed [COMP_W-1:0]      o_y
);
    localparam int N = (STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : STAGES;

    // stage A: reduce angle, start divide by 45
    logic [15:0] n_u;
    logic [15:0] r_u_a, r_mag_a;
    logic [31:0] r_qp_a;
    logic        r_v_a;
    // stage B: quotient and remainder
    logic [9:0]  n_q;
    logic [15:0] n_q45;
    logic [5:0]  n_rem;
    logic [9:0]  r_q_b;
    logic [27:0] r_nr_b;
    logic [15:0] r_mag_b;
    logic        r_v_b;
    // stage C: fraction product
    logic [9:0]  r_q_c;
    logic [56:0] r_fp_c;
    logic [15:0] r_mag_c;
    logic        r_v_c;
    // stage D: binary angle and fold
    logic [31:0] n_phi;
    logic        n_neg;

    logic signed [XY_W-1:0] r_x [0:N];
    logic signed [XY_W-1:0] r_y [0:N];
    logic signed [XY_W-1:0] r_z [0:N];
    logic                   r_neg [0:N];
    logic                   r_v [0:N];

    logic signed [XY_W-1:0]   n_xs, n_ys;
    logic signed [65:0]       r_px, r_py;
    logic                     r_v_g;
    logic signed [65:0]       n_rx, n_ry;
    logic signed [COMP_W-1:0] r_ox, r_oy;
    logic                     r_v_o;

    assign n_u   = (i_angle >= TURN_UNITS) ? (i_angle - TURN_UNITS) : i_angle;
    assign n_q   = r_qp_a[30:21];
    assign n_q45 = 16'(n_q * DIV45);
    assign n_rem = 6'(r_u_a - n_q45);
    assign n_phi = {r_q_c, 22'b0} + {10'b0, r_fp_c[55:34]};
    assign n_neg = (n_phi[31:30] == 2'b01) || (n_phi[31:30] == 2'b10);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u_a   <= n_u;
            r_qp_a  <= n_u * RECIP45_Q21;
            r_mag_a <= i_mag;
            r_q_b   <= n_q;
            r_nr_b  <= {n_rem, 22'b0} + 28'd22;
            r_mag_b <= r_mag_a;
            r_q_c   <= r_q_b;
            r_fp_c  <= r_nr_b * RECIP45_Q34;
            r_mag_c <= r_mag_b;
            r_x[0]  <= XY_W'({r_mag_c, 14'b0});
            r_y[0]  <= '0;
            r_z[0]  <= XY_W'($signed(n_neg ? (n_phi ^ HALF_TURN) : n_phi));
            r_neg[0] <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
            r_v_c <= 1'b0;
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v_a <= i_valid;
            r_v_b <= r_v_a;
            r_v_c <= r_v_b;
            r_v[0] <= r_v_c;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        logic signed [XY_W-1:0] w_dx, w_dy, w_at;
        assign w_dx = r_y[i] >>> i;
        assign w_dy = r_x[i] >>> i;
        assign w_at = XY_W'(atan_val(i));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - w_dx;
                    r_y[i+1] <= r_y[i] + w_dy;
                    r_z[i+1] <= r_z[i] - w_at;
                end else begin
                    r_x[i+1] <= r_x[i] + w_dx;
                    r_y[i+1] <= r_y[i] - w_dy;
                    r_z[i+1] <= r_z[i] + w_at;
                end
                r_neg[i+1] <= r_neg[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end
    end

    assign n_xs = r_neg[N] ? -r_x[N] : r_x[N];
    assign n_ys = r_neg[N] ? -r_y[N] : r_y[N];
    assign n_rx = r_px + 66'sd1073741824;
    assign n_ry = r_py + 66'sd1073741824;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= n_xs * $signed({1'b0, GAIN_Q31});
            r_py <= n_ys * $signed({1'b0, GAIN_Q31});
            r_ox <= n_rx[62:31];
            r_oy <= n_ry[62:31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_g <= 1'b0;
            r_v_o <= 1'b0;
        end else if (i_en) begin
            r_v_g <= r_v[N];
            r_v_o <= r_v_g;
        end
    end

    assign o_valid = r_v_o;
    assign o_x     = r_ox;
    assign o_y     = r_oy;
endmodule
`default_nettype wire

@@ design/pva_vectoring.sv @@
// Pipelined component sum, CORDIC vectoring and output scaling.
`timescale 1ns / 1ps
`default_nettype none
module pva_vectoring
    import pva_pkg::*;
#(
    parameter int STAGES = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic signed [COMP_W-1:0] i_xa,
    input  wire logic signed [COMP_W-1:0] i_ya,
    input  wire logic signed [COMP_W-1:0] i_xb,
    input  wire logic signed [COMP_W-1:0] i_yb,
    output logic                          o_valid,
    output logic [16:0]                   o_magnitude,
    output logic [15:0]                   o_direction
);
    localparam int N = (STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : STAGES;

    logic signed [VEC_W-1:0] n_sx, n_sy;
    logic                    n_zero;

    logic signed [VEC_W-1:0] r_x [0:N];
    logic signed [VEC_W-1:0] r_y [0:N];
    logic [31:0]             r_z [0:N];
    logic                    r_zero [0:N];
    logic                    r_v [0:N];

    logic [34:0] n_xc;
    logic [65:0] r_pm;
    logic [47:0] r_pd;
    logic        r_zero_f, r_v_f;
    logic [65:0] n_pm;
    logic [47:0] n_pd;
    logic [16:0] n_mag;
    logic [15:0] n_dir;
    logic [16:0] r_mag;
    logic [15:0] r_dir;
    logic        r_v_o;

    assign n_sx   = VEC_W'(i_xa) + VEC_W'(i_xb);
    assign n_sy   = VEC_W'(i_ya) + VEC_W'(i_yb);
    assign n_zero = (n_sx == 0) && (n_sy == 0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // fold left half plane onto the right
            if (n_sx < 0) begin
                r_x[0] <= -n_sx;
                r_y[0] <= -n_sy;
                r_z[0] <= HALF_TURN;
            end else begin
                r_x[0] <= n_sx;
                r_y[0] <= n_sy;
                r_z[0] <= '0;
            end
            r_zero[0] <= n_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_vec
        logic signed [VEC_W-1:0] w_dx, w_dy;
        assign w_dx = r_y[i] >>> i;
        assign w_dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + w_dx;
                    r_y[i+1] <= r_y[i] - w_dy;
                    r_z[i+1] <= r_z[i] + atan_val(i);
                end else begin
                    r_x[i+1] <= r_x[i] - w_dx;
                    r_y[i+1] <= r_y[i] + w_dy;
                    r_z[i+1] <= r_z[i] - atan_val(i);
                end
                r_zero[i+1] <= r_zero[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end
    end

    assign n_xc = (r_x[N] < 0) ? '0 : r_x[N][34:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pm     <= n_xc * GAIN_Q31;
            r_pd     <= r_z[N] * TURN_UNITS;
            r_zero_f <= r_zero[N];
        end
    end

    assign n_pm  = r_pm + 66'h0000_1000_0000_0000;
    assign n_pd  = r_pd + 48'h0000_8000_0000;
    assign n_mag = (n_pm[65:45] > 21'h1FFFF) ? 17'h1FFFF : n_pm[61:45];
    assign n_dir = (n_pd[47:32] >= TURN_UNITS) ? 16'd0 : n_pd[47:32];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= r_zero_f ? 17'd0 : n_mag;
            r_dir <= r_zero_f ? 16'd0 : n_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_f <= 1'b0;
            r_v_o <= 1'b0;
        end else if (i_en) begin
            r_v_f <= r_v[N];
            r_v_o <= r_v_f;
        end
    end

    assign o_valid     = r_v_o;
    assign o_magnitude = r_mag;
    assign o_direction = r_dir;
endmodule
`default_nettype wire

@@ design/polar_vector_add.sv @@
// Top level of the polar vector adder.
// Usage:
//   i_in carries one item: two vectors, magnitudes unsigned Q8.8 and angles in
//   1/128 degree units (values 46080 and up are reduced by one turn).
//   o_out carries the resultant: magnitude Q9.8 and direction 0..46079.
//   Both channels use valid/ready; an item moves when both are high.
// Throughput: one item per cycle. The whole datapath is one pipeline that
//   advances on a common enable, so an item enters every cycle while the
//   output register is empty or being taken.
// Pipeline, N = min(CORDIC_STAGES, 24): angle scaling, N rotation stages,
//   gain product and rounding, component sum and fold, N vectoring stages
//   and output scaling.
// Stall: when the result waits and o_out.ready is low, the pipeline holds
//   and i_in.ready drops; nothing is lost or repeated.
// Reset: synchronous, active low; clears all valid bits, the pipeline is
//   empty and ready on the next cycle.
`timescale 1ns / 1ps
`default_nettype none
module polar_vector_add
    import pva_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pva_in_if.sink     i_in,
    pva_out_if.source  o_out
);
    logic                    w_en;
    logic                    w_va, w_vb;
    logic signed [COMP_W-1:0] w_xa, w_ya, w_xb, w_yb;
    logic                    w_vo;

    // advance everything unless the result is waiting
    assign w_en       = !w_vo || o_out.ready;
    assign i_in.ready = w_en;

    pva_polar_to_xy #(.STAGES(CORDIC_STAGES)) u_vec_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_mag   (i_in.mag_a),
        .i_angle (i_in.angle_a),
        .o_valid (w_va),
        .o_x     (w_xa),
        .o_y     (w_ya)
    );

    pva_polar_to_xy #(.STAGES(CORDIC_STAGES)) u_vec_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_mag   (i_in.mag_b),
        .i_angle (i_in.angle_b),
        .o_valid (w_vb),
        .o_x     (w_xb),
        .o_y     (w_yb)
    );

    pva_vectoring #(.STAGES(CORDIC_STAGES)) u_vectoring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_va),
        .i_xa        (w_xa),
        .i_ya        (w_ya),
        .i_xb        (w_xb),
        .i_yb        (w_yb),
        .o_valid     (w_vo),
        .o_magnitude (o_out.sum_magnitude),
        .o_direction (o_out.sum_direction)
    );

    assign o_out.valid = w_vo;

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_va == w_vb)
        else $error("conversion lanes out of step");

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vo |-> (o_out.sum_direction < TURN_UNITS))
        else $error("direction out of range");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vo && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while result stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !w_vo)
        else $error("result valid right after reset");
endmodule
`default_nettype wire

@@ dv/polar_vector_add_test.sv @@
// Testbench for the polar vector adder: bit-exact prediction, random stalls on both sides.
`timescale 1ns / 1ps
module polar_vector_add_test;
    import pva_pkg::*;

    localparam int STAGES  = 16;
    localparam int LATENCY = 2 * STAGES + 9;

    typedef struct packed {
        logic [15:0] mag_a;
        logic [15:0] angle_a;
        logic [15:0] mag_b;
        logic [15:0] angle_b;
    } vec_pair_t;

    typedef struct packed {
        logic [16:0] magnitude;
        logic [15:0] direction;
    } resultant_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pva_in_if  in_ch ();
    pva_out_if out_ch ();

    polar_vector_add #(.CORDIC_STAGES(STAGES)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #6 i_clk = ~i_clk;

    resultant_t expected_sums[$];
    int         errors = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_recv_cycles = 0;

    localparam logic [31:0] ATAN_LUT [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // Arithmetic shift with floor, as >>> on signed 64-bit.
    function automatic longint compensate(input longint v);
        return (v * longint'(GAIN_Q31) + (64'sd1 <<< 30)) >>> 31;
    endfunction

    function automatic void polar_to_xy(input logic [15:0] mag, input logic [15:0] ang,
                                        output longint xo, output longint yo);
        logic [63:0] u;
        logic [31:0] phi;
        longint      x, y, z, dx, dy;
        bit          flip;
        int          n;
        n = (STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : STAGES;
        u = {48'd0, ang};
        if (u >= 46080) u -= 46080;
        phi = 32'(((u << 32) + 64'd23040) / 64'd46080);
        flip = (phi[31:30] == 2'd1) || (phi[31:30] == 2'd2);
        if (flip) phi += HALF_TURN;
        z = longint'($signed(phi));
        x = longint'({48'd0, mag}) <<< FRAC_SHIFT;
        y = 0;
        for (int i = 0; i < n; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_LUT[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_LUT[i]);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        xo = compensate(x);
        yo = compensate(y);
    endfunction

    function automatic resultant_t vector_sum(input vec_pair_t p);
        longint      xa, ya, xb, yb, x, y, dx, dy, mag;
        logic [31:0] z;
        logic [63:0] dir;
        resultant_t  r;
        int          n;
        n = (STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : STAGES;
        polar_to_xy(p.mag_a, p.angle_a, xa, ya);
        polar_to_xy(p.mag_b, p.angle_b, xb, yb);
        x = xa + xb;
        y = ya + yb;
        z = 32'd0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < n; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += ATAN_LUT[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_LUT[i];
            end
        end
        if (x < 0) x = 0;
        mag = (x * longint'(GAIN_Q31) + (64'sd1 <<< 44)) >>> 45;
        if (mag > 64'sh1FFFF) mag = 64'sh1FFFF;
        dir = ({32'd0, z} * 64'd46080 + 64'h8000_0000) >> 32;
        if (dir >= 46080) dir = 0;
        r.magnitude = mag[16:0];
        r.direction = dir[15:0];
        return r;
    endfunction

    task automatic send_pair(input vec_pair_t p);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mag_a   <= p.mag_a;
        in_ch.angle_a <= p.angle_a;
        in_ch.mag_b   <= p.mag_b;
        in_ch.angle_b <= p.angle_b;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_sums.push_back(vector_sum(p));
    endtask

    function automatic logic [15:0] rand_angle();
        // Mostly in range, sometimes in the wrap band, sometimes anything.
        case ($urandom_range(9))
            0:       return 16'($urandom_range(65535, 46080));
            1:       return 16'($urandom);
            default: return 16'($urandom_range(46079));
        endcase
    endfunction

    function automatic vec_pair_t rand_pair();
        vec_pair_t p;
        p.mag_a   = 16'($urandom);
        p.mag_b   = 16'($urandom);
        p.angle_a = rand_angle();
        p.angle_b = rand_angle();
        case ($urandom_range(7))
            // Opposite vectors of equal length: near-zero resultant.
            0: begin
                p.mag_b   = p.mag_a;
                p.angle_b = 16'((p.angle_a >= 46080) ? p.angle_a - 23040 :
                            (p.angle_a < 23040 ? p.angle_a + 23040 : p.angle_a - 23040));
            end
            1: p.mag_a = 16'($urandom_range(3));
            2: p.angle_b = p.angle_a;
            default: ;
        endcase
        return p;
    endfunction

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        vec_pair_t list[$];
        list.push_back('{16'd0,     16'd0,     16'd0,     16'd0});
        list.push_back('{16'hFFFF,  16'd0,     16'hFFFF,  16'd0});
        list.push_back('{16'hFFFF,  16'd11520, 16'hFFFF,  16'd11520});
        list.push_back('{16'h0100,  16'd0,     16'h0100,  16'd23040});
        list.push_back('{16'h0100,  16'd11520, 16'h0100,  16'd34560});
        list.push_back('{16'h0100,  16'd46079, 16'd0,     16'd0});
        list.push_back('{16'h0100,  16'd46080, 16'h0200,  16'd65535});
        list.push_back('{16'hFFFF,  16'hFFFF,  16'h5555,  16'hAAAA});
        list.push_back('{16'h0001,  16'd23040, 16'd0,     16'd0});
        list.push_back('{16'h0001,  16'd46079, 16'h0001,  16'd46079});
        list.push_back('{16'h0100,  16'd34560, 16'h0100,  16'd34561});
        list.push_back('{16'h8000,  16'd17280, 16'h8000,  16'd5760});
        list.push_back('{16'hAAAA,  16'h5555,  16'h5555,  16'hAAAA});
        list.push_back('{16'h0100,  16'd0,     16'h0001,  16'd34560});
        foreach (list[i]) send_pair(list[i]);
        wait_drained();
    endtask

    task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_pair(rand_pair());
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_recv_cycles = 200;
        repeat (120) send_pair(rand_pair());
        // Pause the sender until every result is in.
        wait_drained();
        repeat (60) send_pair(rand_pair());
        wait_drained();
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_recv_cycles > 0) begin
                hold_recv_cycles <= hold_recv_cycles - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Result check against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_sums.size() == 0) begin
                $error("unexpected result: sum_magnitude=%0d sum_direction=%0d",
                       out_ch.sum_magnitude, out_ch.sum_direction);
                errors++;
            end else begin
                resultant_t want;
                want = expected_sums.pop_front();
                if (out_ch.sum_magnitude !== want.magnitude) begin
                    $error("sum_magnitude: expected %0d, got %0d",
                           want.magnitude, out_ch.sum_magnitude);
                    errors++;
                end
                if (out_ch.sum_direction !== want.direction) begin
                    $error("sum_direction: expected %0d, got %0d",
                           want.direction, out_ch.sum_direction);
                    errors++;
                end
            end
        end
    end

    initial begin
        #(12 * 400000);
        $display("FAILURE");
        $finish;
    end

    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.mag_a   <= '0;
        in_ch.angle_a <= '0;
        in_ch.mag_b   <= '0;
        in_ch.angle_b <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(450, 0, 0);
        test_random_phase(450, 51, 0);
        test_random_phase(450, 0, 51);
        test_random_phase(450, 16, 16);
        test_backpressure();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && expected_sums.size() == 0) begin
            $display("SUCCESS");
        end else begin
            if (expected_sums.size() != 0)
                $error("%0d results never arrived", expected_sums.size());
            $display("FAILURE");
        end
        $finish;
    end
endmodule

@@ files.f @@
design/pva_pkg.sv
design/pva_in_if.sv
design/pva_out_if.sv
design/pva_polar_to_xy.sv
design/pva_vectoring.sv
design/polar_vector_add.sv
dv/polar_vector_add_test.sv
